// ===== rtl/core/lzssd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzssd_pkg
// Shared types and constants of the LZSS bit-stream decompressor.
// ----------------------------------------------------------------------------
`default_nettype none

package lzssd_pkg;

    localparam int OFFSET_BITS = 11;
    localparam int LENGTH_BITS = 4;

    localparam int ADDR_W    = OFFSET_BITS;
    localparam int WIN_DEPTH = 1 << ADDR_W;
    localparam int LOOK_SIZE = (1 << LENGTH_BITS) + 1;
    localparam int FILL_W    = ADDR_W + 1;
    localparam int FIELD_W   = ADDR_W;
    localparam int FCNT_W    = $clog2(ADDR_W + 1);
    localparam int REM_W     = LENGTH_BITS + 1;

    localparam logic [ADDR_W-1:0] START_ADDR = ADDR_W'(WIN_DEPTH - LOOK_SIZE);
    localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(WIN_DEPTH);
    localparam logic [7:0]        SPACE_CHAR = 8'h20;

    typedef struct packed {
        logic [7:0] compressed_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_item_t;

    typedef struct packed {
        logic              wr_en;
        logic [7:0]        wr_data;
        logic [ADDR_W-1:0] rd_addr;
        logic              restart;
    } win_ctrl_t;

    typedef struct packed {
        logic       push;
        logic [7:0] push_byte;
        logic       flush;
    } ob_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/lzssd_window.sv =====
// ----------------------------------------------------------------------------
// lzssd_window
// History ring window: one write and one registered read per cycle, write
// pointer, fill count that stands in for the reset contents, and a bypass for
// a read of the address written at the same edge.
// ----------------------------------------------------------------------------
`default_nettype none

module lzssd_window (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lzssd_pkg::win_ctrl_t ctrl,
    output logic [7:0]           rd_byte
);
    import lzssd_pkg::*;

    logic [7:0]        mem [WIN_DEPTH];
    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [7:0]        rdata_reg;
    logic [ADDR_W-1:0] raddr_reg;
    logic [7:0]        fwd_data_reg;
    logic              fwd_reg, fwd_next;
    logic              filled_reg, filled_next;
    logic [ADDR_W-1:0] rd_rel;
    logic [7:0]        reset_byte;

    // entries written since reset form one run starting at START_ADDR
    assign rd_rel      = ctrl.rd_addr - START_ADDR;
    assign filled_next = {1'b0, rd_rel} < fill_reg;
    assign fwd_next    = ctrl.wr_en && (ctrl.rd_addr == wp_reg);

    always_comb
    begin
        wp_next   = wp_reg;
        fill_next = fill_reg;
        if (ctrl.restart)
        begin
            wp_next   = START_ADDR;
            fill_next = '0;
        end
        else if (ctrl.wr_en)
        begin
            wp_next = wp_reg + ADDR_W'(1);
            if (fill_reg != FILL_FULL)
                fill_next = fill_reg + FILL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
            mem[wp_reg] <= ctrl.wr_data;
        rdata_reg    <= mem[ctrl.rd_addr];
        raddr_reg    <= ctrl.rd_addr;
        fwd_data_reg <= ctrl.wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg     <= START_ADDR;
            fill_reg   <= '0;
            fwd_reg    <= 1'b0;
            filled_reg <= 1'b0;
        end
        else
        begin
            wp_reg     <= wp_next;
            fill_reg   <= fill_next;
            fwd_reg    <= fwd_next;
            filled_reg <= filled_next;
        end
    end

    assign reset_byte = (raddr_reg < START_ADDR) ? SPACE_CHAR : 8'h00;
    assign rd_byte    = fwd_reg ? fwd_data_reg : (filled_reg ? rdata_reg : reset_byte);

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_FULL)
        else $error("window fill count overran the window");

    a_wp_advance: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.wr_en && !ctrl.restart |=> wp_reg == $past(wp_reg) + ADDR_W'(1))
        else $error("write pointer did not advance on a write");

    a_restart_clean: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.restart |=> fill_reg == '0 && wp_reg == START_ADDR)
        else $error("window restart did not restore pointer and fill");

endmodule

`default_nettype wire

// ===== rtl/core/lzssd_out_buf.sv =====
// ----------------------------------------------------------------------------
// lzssd_out_buf
// One-byte holding stage ahead of the output register: a byte is held until
// the next one arrives or the item ends, so its end-of-run mark is known.
// ----------------------------------------------------------------------------
`default_nettype none

module lzssd_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lzssd_pkg::ob_ctrl_t  ctrl,
    output logic                 room,
    output logic                 result_valid,
    input  logic                 result_stall,
    output lzssd_pkg::out_item_t result
);
    import lzssd_pkg::*;

    logic       pend_valid_reg, pend_valid_next;
    logic [7:0] pend_byte_reg;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_reg, out_next;
    logic       out_free;
    logic       out_load;

    assign out_free = !out_valid_reg || !result_stall;
    assign room     = !pend_valid_reg || out_free;
    assign out_load = pend_valid_reg && out_free && (ctrl.push || ctrl.flush);

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        if (out_load)
        begin
            out_valid_next       = 1'b1;
            out_next.out_byte    = pend_byte_reg;
            out_next.last_of_run = ctrl.flush;
        end
        else if (!result_stall)
            out_valid_next = 1'b0;
        if (ctrl.push && room)
            pend_valid_next = 1'b1;
        else if (ctrl.flush && out_free)
            pend_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push && room)
            pend_byte_reg <= ctrl.push_byte;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_no_push_flush: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.push && ctrl.flush))
        else $error("push and flush requested together");

    a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.flush && out_free |=> !pend_valid_reg)
        else $error("flush left a byte in the holding stage");

    a_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.push && room |=> pend_valid_reg)
        else $error("pushed byte not held");

endmodule

`default_nettype wire

// ===== rtl/core/lzss_bitstream_decompressor.sv =====
// Sequence: a byte is decoded one bit per cycle while the output has room, then
// each copy token it completes runs a prime step and L+2 byte copies, then a flush.
// Input: a new byte is taken only after the last one is flushed, later still
// under output stalls; set by the serial bit parser and the single window read port.
// Reset: async; the window reads as its reset contents at once (fill count),
// so there is no clearing pass. last_byte restores the same state at item end.
// ----------------------------------------------------------------------------
// lzss_bitstream_decompressor
// LZSS token parser (flag, literal, offset, length) over a serial bit stream,
// with a window copy sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module lzss_bitstream_decompressor (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  lzssd_pkg::in_item_t  item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output lzssd_pkg::out_item_t result
);
    import lzssd_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SHIFT = 5'b00010,
        S_PRIME = 5'b00100,
        S_COPY  = 5'b01000,
        S_FLUSH = 5'b10000
    } state_t;

    typedef enum logic [3:0] {
        PH_FLAG = 4'b0001,
        PH_LIT  = 4'b0010,
        PH_OFF  = 4'b0100,
        PH_LEN  = 4'b1000
    } phase_t;

    localparam logic [FCNT_W-1:0] NEED_LIT  = FCNT_W'(8);
    localparam logic [FCNT_W-1:0] NEED_OFF  = FCNT_W'(OFFSET_BITS);
    localparam logic [FCNT_W-1:0] NEED_LEN  = FCNT_W'(LENGTH_BITS);
    localparam logic [3:0]        BYTE_BITS = 4'd8;

    state_t             state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic [7:0]         sh_reg, sh_next;
    logic [3:0]         bits_left_reg, bits_left_next;
    logic               last_reg, last_next;
    logic [FIELD_W-1:0] field_reg, field_next;
    logic [FCNT_W-1:0]  fcnt_reg, fcnt_next;
    logic [ADDR_W-1:0]  offset_reg, offset_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [ADDR_W-1:0]  cur_reg, cur_next;

    logic               in_bit;
    logic [FIELD_W-1:0] field_shift;
    logic [FCNT_W-1:0]  need;
    logic               field_done;
    logic               consume;
    logic               accept;
    logic               room;
    logic [7:0]         copy_byte;
    win_ctrl_t          win_ctrl;
    ob_ctrl_t           ob_ctrl;

    assign item_stall  = (state_reg != S_IDLE);
    assign accept      = item_valid && !item_stall;
    assign in_bit      = sh_reg[7];
    assign field_shift = {field_reg[FIELD_W-2:0], in_bit};

    always_comb
    begin
        unique case (phase_reg)
            PH_LIT:  need = NEED_LIT;
            PH_OFF:  need = NEED_OFF;
            default: need = NEED_LEN;
        endcase
    end

    assign field_done = (fcnt_reg + FCNT_W'(1)) == need;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        sh_next        = sh_reg;
        bits_left_next = bits_left_reg;
        last_next      = last_reg;
        field_next     = field_reg;
        fcnt_next      = fcnt_reg;
        offset_next    = offset_reg;
        rem_next       = rem_reg;
        cur_next       = cur_reg;
        consume        = 1'b0;
        win_ctrl       = '{wr_en: 1'b0, wr_data: 8'h00, rd_addr: cur_reg, restart: 1'b0};
        ob_ctrl        = '{push: 1'b0, push_byte: 8'h00, flush: 1'b0};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sh_next        = item.compressed_byte;
                    last_next      = item.last_byte;
                    bits_left_next = BYTE_BITS;
                    state_next     = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                unique case (phase_reg)
                    PH_FLAG:
                    begin
                        consume    = 1'b1;
                        phase_next = in_bit ? PH_LIT : PH_OFF;
                        field_next = '0;
                        fcnt_next  = '0;
                    end
                    PH_LIT:
                    begin
                        if (!field_done)
                        begin
                            consume    = 1'b1;
                            field_next = field_shift;
                            fcnt_next  = fcnt_reg + FCNT_W'(1);
                        end
                        else if (room)
                        begin
                            consume           = 1'b1;
                            ob_ctrl.push      = 1'b1;
                            ob_ctrl.push_byte = field_shift[7:0];
                            win_ctrl.wr_en    = 1'b1;
                            win_ctrl.wr_data  = field_shift[7:0];
                            phase_next        = PH_FLAG;
                            field_next        = '0;
                            fcnt_next         = '0;
                        end
                    end
                    PH_OFF:
                    begin
                        consume = 1'b1;
                        if (field_done)
                        begin
                            offset_next = field_shift[ADDR_W-1:0];
                            phase_next  = PH_LEN;
                            field_next  = '0;
                            fcnt_next   = '0;
                        end
                        else
                        begin
                            field_next = field_shift;
                            fcnt_next  = fcnt_reg + FCNT_W'(1);
                        end
                    end
                    PH_LEN:
                    begin
                        consume = 1'b1;
                        if (field_done)
                        begin
                            rem_next   = REM_W'(field_shift[LENGTH_BITS-1:0]) + REM_W'(2);
                            phase_next = PH_FLAG;
                            field_next = '0;
                            fcnt_next  = '0;
                            state_next = S_PRIME;
                        end
                        else
                        begin
                            field_next = field_shift;
                            fcnt_next  = fcnt_reg + FCNT_W'(1);
                        end
                    end
                    default: ;
                endcase
                if (consume)
                begin
                    sh_next        = {sh_reg[6:0], 1'b0};
                    bits_left_next = bits_left_reg - 4'd1;
                    if (state_next == S_SHIFT && bits_left_reg == 4'd1)
                        state_next = S_FLUSH;
                end
            end
            S_PRIME:
            begin
                win_ctrl.rd_addr = offset_reg;
                cur_next         = offset_reg;
                state_next       = S_COPY;
            end
            S_COPY:
            begin
                if (room)
                begin
                    ob_ctrl.push      = 1'b1;
                    ob_ctrl.push_byte = copy_byte;
                    win_ctrl.wr_en    = 1'b1;
                    win_ctrl.wr_data  = copy_byte;
                    win_ctrl.rd_addr  = cur_reg + ADDR_W'(1);
                    cur_next          = cur_reg + ADDR_W'(1);
                    rem_next          = rem_reg - REM_W'(1);
                    if (rem_reg == REM_W'(1))
                        state_next = (bits_left_reg == 4'd0) ? S_FLUSH : S_SHIFT;
                end
            end
            S_FLUSH:
            begin
                ob_ctrl.flush = 1'b1;
                if (room)
                begin
                    state_next = S_IDLE;
                    if (last_reg)
                    begin
                        // end of stream: drop partial token and padding
                        win_ctrl.restart = 1'b1;
                        phase_next       = PH_FLAG;
                        field_next       = '0;
                        fcnt_next        = '0;
                        offset_next      = '0;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        sh_reg   <= sh_next;
        rem_reg  <= rem_next;
        cur_reg  <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_FLAG;
            bits_left_reg <= '0;
            last_reg      <= 1'b0;
            field_reg     <= '0;
            fcnt_reg      <= '0;
            offset_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            bits_left_reg <= bits_left_next;
            last_reg      <= last_next;
            field_reg     <= field_next;
            fcnt_reg      <= fcnt_next;
            offset_reg    <= offset_next;
        end
    end

    lzssd_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (win_ctrl),
        .rd_byte (copy_byte)
    );

    lzssd_out_buf u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ob_ctrl),
        .room         (room),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    a_write_with_push: assert property (@(posedge clk) disable iff (!rst_n)
        win_ctrl.wr_en |-> ob_ctrl.push && room)
        else $error("window write without a matching output byte");

    a_copy_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_COPY |-> rem_reg != '0)
        else $error("copy sequencer running with nothing left");

    a_shift_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SHIFT |-> bits_left_reg != 4'd0)
        else $error("bit parser running past the end of the byte");

    a_prime_to_copy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PRIME |=> state_reg == S_COPY && cur_reg == $past(offset_reg))
        else $error("copy did not start at the match offset");

endmodule

`default_nettype wire

// ===== sim/lzss_stream_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_stream_checker
// Watches both channels of the LZSS decompressor. It decodes every accepted
// compressed byte with its own token parser and window copy, and compares each
// accepted result with the oldest decoded byte still pending.
// ----------------------------------------------------------------------------

module lzss_stream_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic                 item_stall,
    input  lzssd_pkg::in_item_t  item,
    input  logic                 result_valid,
    input  logic                 result_stall,
    input  lzssd_pkg::out_item_t result,
    output int                   fails,
    output int                   pending,
    output int                   results_seen
);
    import lzssd_pkg::*;

    typedef enum logic [1:0] {TK_FLAG, TK_LITERAL, TK_OFFSET, TK_LENGTH} token_phase_t;

    logic [7:0]        win_model [WIN_DEPTH];
    logic [ADDR_W-1:0] win_wr_pos;
    token_phase_t      tok_phase;
    logic [FIELD_W-1:0] tok_bits;
    int                tok_nbits;
    logic [ADDR_W-1:0] copy_base;

    out_item_t decoded_q[$];
    out_item_t byte_run_q[$];
    int        fail_total = 0;
    int        got_total = 0;

    task automatic clear_decoder();
        for (int i = 0; i < WIN_DEPTH; i++)
            win_model[i] = (i < int'(START_ADDR)) ? SPACE_CHAR : 8'h00;
        win_wr_pos = START_ADDR;
        tok_phase  = TK_FLAG;
        tok_bits   = '0;
        tok_nbits  = 0;
        copy_base  = '0;
    endtask

    function automatic int field_len(token_phase_t ph);
        if (ph == TK_LITERAL)
            return 8;
        if (ph == TK_OFFSET)
            return OFFSET_BITS;
        return LENGTH_BITS;
    endfunction

    // every decoded byte also lands in the window
    task automatic put_decoded(input logic [7:0] v);
        out_item_t o;
        win_model[win_wr_pos] = v;
        win_wr_pos = win_wr_pos + 1'b1;
        o.out_byte    = v;
        o.last_of_run = 1'b0;
        byte_run_q.push_back(o);
    endtask

    task automatic decode_byte(input in_item_t it);
        logic              b;
        int                total;
        logic [ADDR_W-1:0] rd_at;
        out_item_t         o;
        for (int p = 7; p >= 0; p--) begin
            b = it.compressed_byte[p];
            if (tok_phase == TK_FLAG) begin
                tok_phase = b ? TK_LITERAL : TK_OFFSET;
                tok_bits  = '0;
                tok_nbits = 0;
            end
            else begin
                tok_bits = {tok_bits[FIELD_W-2:0], b};
                tok_nbits++;
                if (tok_nbits == field_len(tok_phase)) begin
                    case (tok_phase)
                        TK_LITERAL: begin
                            put_decoded(tok_bits[7:0]);
                            tok_phase = TK_FLAG;
                        end
                        TK_OFFSET: begin
                            copy_base = tok_bits[ADDR_W-1:0];
                            tok_phase = TK_LENGTH;
                        end
                        default: begin
                            // byte-at-a-time copy, so overlap repeats fresh bytes
                            total = int'(tok_bits[LENGTH_BITS-1:0]) + 2;
                            for (int k = 0; k < total; k++) begin
                                rd_at = copy_base + ADDR_W'(k);
                                put_decoded(win_model[rd_at]);
                            end
                            tok_phase = TK_FLAG;
                        end
                    endcase
                    tok_bits  = '0;
                    tok_nbits = 0;
                end
            end
        end
        if (byte_run_q.size() > 0) begin
            o = byte_run_q[byte_run_q.size()-1];
            o.last_of_run = 1'b1;
            byte_run_q[byte_run_q.size()-1] = o;
        end
        foreach (byte_run_q[i])
            decoded_q.push_back(byte_run_q[i]);
        byte_run_q.delete();
        // end of stream drops any partial token and restores the window
        if (it.last_byte)
            clear_decoder();
    endtask

    task automatic report_mismatch(input string what, input int want, input int seen);
        $display("MISMATCH %s: expected 0x%0h, got 0x%0h at result %0d",
                 what, want, seen, got_total);
        fail_total++;
    endtask

    always @(posedge clk or negedge rst_n) begin : monitor
        out_item_t exp_item;
        if (!rst_n) begin
            clear_decoder();
            decoded_q.delete();
        end
        else begin
            if (result_valid && !result_stall) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch("result with nothing pending", 0, int'(result.out_byte));
                end
                else begin
                    exp_item = decoded_q.pop_front();
                    if (result.out_byte !== exp_item.out_byte)
                        report_mismatch("out_byte", int'(exp_item.out_byte),
                                        int'(result.out_byte));
                    if (result.last_of_run !== exp_item.last_of_run)
                        report_mismatch("last_of_run", int'(exp_item.last_of_run),
                                        int'(result.last_of_run));
                end
                got_total++;
            end
            if (item_valid && !item_stall)
                decode_byte(item);
        end
        fails        <= fail_total;
        pending      <= decoded_q.size();
        results_seen <= got_total;
    end

endmodule

// ===== sim/tb_lzss_bitstream_decompressor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lzss_bitstream_decompressor
// Builds LZSS token streams (literals, window copies, truncated and noisy
// streams), packs them into compressed bytes and feeds them in bursts while
// the result side stalls on its own pattern; the checker predicts and compares.
// ----------------------------------------------------------------------------

module tb_lzss_bitstream_decompressor;
    import lzssd_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 400;

    logic      clk;
    logic      rst_n;
    logic      item_valid = 1'b0;
    logic      item_stall;
    in_item_t  item = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result;

    int fails;
    int pending;
    int results_seen;

    int cycle_count = 0;
    int items_sent = 0;
    int streams_sent = 0;
    int burst_left = 0;

    bit                stream_q[$];
    logic [ADDR_W-1:0] est_wpos = START_ADDR;

    lzss_bitstream_decompressor dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    lzss_stream_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .fails        (fails),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count, pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result-side stall: the mode is redrawn when its random hold runs out, and runs are capped
    int stall_mode = 0;
    int stall_left = 0;
    int stall_run = 0;

    always @(posedge clk)
    begin : stall_gen
        logic want;
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(40, 200);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       want = 1'b0;
            1:       want = 1'($urandom_range(0, 1));
            2:       want = ($urandom_range(0, 3) != 0);
            default: want = (cycle_count % 11) < 4;
        endcase
        if (want && stall_run < 8)
        begin
            result_stall <= 1'b1;
            stall_run    <= stall_run + 1;
        end
        else
        begin
            result_stall <= 1'b0;
            stall_run    <= 0;
        end
    end

    task automatic push_bits(input int unsigned v, input int n);
        for (int i = n - 1; i >= 0; i--)
            stream_q.push_back(v[i]);
    endtask

    task automatic put_literal(input logic [7:0] v);
        push_bits(1, 1);
        push_bits(v, 8);
        est_wpos = est_wpos + 1'b1;
    endtask

    task automatic put_copy(input int unsigned off, input int unsigned len);
        push_bits(0, 1);
        push_bits(off, OFFSET_BITS);
        push_bits(len, LENGTH_BITS);
        est_wpos = est_wpos + ADDR_W'(len + 2);
    endtask

    function automatic int unsigned pick_offset();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return WIN_DEPTH - 1;
            2:       return int'(est_wpos);
            3:       return $urandom_range(0, WIN_DEPTH - 1);
            default: return int'(ADDR_W'(est_wpos - ADDR_W'($urandom_range(1, 24))));
        endcase
    endfunction

    task automatic random_token();
        if ($urandom_range(0, 1) == 0)
            put_literal(8'($urandom_range(0, 255)));
        else
            put_copy(pick_offset(), $urandom_range(0, (1 << LENGTH_BITS) - 1));
    endtask

    // one byte transfer; the sender may idle between bursts
    task automatic transfer_byte(input logic [7:0] v, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        item_valid <= 1'b1;
        item       <= '{compressed_byte: v, last_byte: last};
        @(posedge clk);
        while (item_stall) @(posedge clk);
        items_sent++;
    endtask

    // drop trailing bits for a truncated stream, pad to a byte, send with last
    task automatic send_stream(input int drop);
        logic [7:0] v;
        int         nbytes;
        repeat (drop)
            if (stream_q.size() > 0)
                void'(stream_q.pop_back());
        while (stream_q.size() % 8 != 0)
            stream_q.push_back(1'($urandom_range(0, 1)));
        if (stream_q.size() == 0)
            push_bits($urandom_range(0, 255), 8);
        nbytes = stream_q.size() / 8;
        for (int i = 0; i < nbytes; i++)
        begin
            for (int j = 7; j >= 0; j--)
                v[j] = stream_q.pop_front();
            transfer_byte(v, i == nbytes - 1);
        end
        est_wpos = START_ADDR;
        streams_sent++;
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int  sel;
        int  nb;
        bit  mid_drain;
        mid_drain = 1'b0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes of literals and copy fields, overlap, wrap past the top
        put_literal(8'h00);
        put_literal(8'hFF);
        put_copy(WIN_DEPTH - 1, 0);
        put_copy(0, (1 << LENGTH_BITS) - 1);
        put_copy(est_wpos - 1'b1, (1 << LENGTH_BITS) - 1);
        put_copy(est_wpos, 3);
        put_literal(8'hA5);
        put_copy(START_ADDR + 2, 4);
        send_stream(5);
        // after end of stream the window must read as reset again
        put_copy(START_ADDR + 5, 2);
        put_literal(8'h5A);
        put_copy(0, 0);
        send_stream(0);
        // byte completing no token, ends the stream
        transfer_byte(8'h00, 1'b1);
        wait_drained();

        while (items_sent < RANDOM_ITEMS)
        begin
            if (!mid_drain && items_sent >= RANDOM_ITEMS / 2)
            begin
                wait_drained();
                mid_drain = 1'b1;
            end
            sel = $urandom_range(0, 9);
            if (sel < 8)
            begin
                repeat ($urandom_range(1, 12)) random_token();
                send_stream((sel == 7) ? $urandom_range(1, 14) : 0);
            end
            else
            begin
                nb = $urandom_range(1, 4);
                for (int i = 0; i < nb; i++)
                    transfer_byte(8'($urandom_range(0, 255)),
                                  (i == nb - 1) || ($urandom_range(0, 3) == 0));
                est_wpos = START_ADDR;
            end
        end

        wait_drained();
        repeat (64) @(posedge clk);
        $display("covered %0d compressed bytes in %0d token streams, %0d decoded bytes checked",
                 items_sent, streams_sent, results_seen);
        $display("literals, copies with overlap and wrap, truncated streams and noise bytes");
        if (fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
